@@ src/pidw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidw_pkg
// Shared widths, codes, reset values and unit request/response structs for
// the serial PID controller with anti-windup clamp.
// ----------------------------------------------------------------------------
package pidw_pkg;

	// field widths
	localparam int ERR_W    = 32;
	localparam int DT_W     = 32;
	localparam int GAIN_W   = 48;
	localparam int LIM_W    = 63;
	localparam int NPT_W    = 16;
	localparam int INTEG_W  = 64;
	localparam int CTRL_W   = 64;
	localparam int FUNC_W   = 2;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 63;
	localparam int IN_DATA_W = 128;

	// serial units
	localparam int MUL_A_W  = 48;
	localparam int MUL_B_W  = 64;
	localparam int PROD_W   = 112;
	localparam int DIVD_W   = 80;
	localparam int DIVS_W   = 32;
	localparam int CNT_W    = 7;
	localparam int ANG_W    = 33;
	localparam int SUM_W    = 96;

	// iteration counts of the divider
	localparam logic [CNT_W-1:0] DIV_CNT_ANG = CNT_W'(ANG_W);
	localparam logic [CNT_W-1:0] DIV_CNT_DER = CNT_W'(DIVD_W);

	// item kinds
	localparam logic [FUNC_W-1:0] FUNC_LINEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ANGULAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_WINDUP_LIM = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEPS_TURN = 3'd4;

	// register reset values
	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 48'd82463372;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 48'd0;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 48'd5497558;
	localparam logic [LIM_W-1:0]  WINDUP_LIM_RST = {LIM_W{1'b1}};
	localparam logic [NPT_W-1:0]  STEPS_TURN_RST = 16'd4096;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
		logic [CNT_W-1:0]  count;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quot;
		logic [DIVS_W-1:0] rem;
	} div_rsp_t;

endpackage

@@ src/pidw_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidw_mul
// Bit-serial unsigned shift-add multiplier. One multiplier bit per cycle,
// LSB first; finishes as soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module pidw_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  pidw_pkg::mul_req_t req,
	output pidw_pkg::mul_rsp_t rsp
);

	logic                         busy_q;
	logic [pidw_pkg::PROD_W-1:0]  a_q;
	logic [pidw_pkg::PROD_W-1:0]  acc_q;
	logic [pidw_pkg::MUL_B_W-1:0] b_q;
	logic                         b_zero;

	assign b_zero = (b_q == '0);

	// busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_zero) begin
			busy_q <= 1'b0;
		end
	end

	// shift-add datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= pidw_pkg::PROD_W'(req.a);
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q && !b_zero) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign rsp.done = busy_q && b_zero;
	assign rsp.prod = acc_q;

endmodule

@@ src/pidw_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidw_div
// Restoring unsigned divider, one quotient bit per cycle. The dividend is
// taken MSB first for a given number of steps.
// ----------------------------------------------------------------------------
module pidw_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pidw_pkg::div_req_t req,
	output pidw_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic [pidw_pkg::CNT_W-1:0]    cnt_q;
	logic [pidw_pkg::DIVD_W-1:0]   n_q;
	logic [pidw_pkg::DIVS_W-1:0]   d_q;
	logic [pidw_pkg::DIVS_W-1:0]   r_q;
	logic [pidw_pkg::DIVS_W:0]     trial;
	logic                          ge;
	logic [pidw_pkg::DIVS_W:0]     trial_sub;

	// next partial remainder
	assign trial     = {r_q, n_q[pidw_pkg::DIVD_W-1]};
	assign ge        = (trial >= {1'b0, d_q});
	assign trial_sub = trial - {1'b0, d_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.count;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.dividend;
			d_q <= req.divisor;
			r_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			n_q <= {n_q[pidw_pkg::DIVD_W-2:0], ge};
			r_q <= ge ? trial_sub[pidw_pkg::DIVS_W-1:0] : trial[pidw_pkg::DIVS_W-1:0];
		end
	end

	assign rsp.done = busy_q && (cnt_q == '0);
	assign rsp.quot = n_q;
	assign rsp.rem  = r_q;

endmodule

@@ src/pid_controller_windup_angular.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_windup_angular
// Fixed-point PID step with anti-windup clamp and angular error wrap.
// ----------------------------------------------------------------------------
// Usage:
//  - Input words arrive on s_axis_*; tuser carries the item kind (linear
//    update, angular update, clear state). One word is taken at a time:
//    s_axis_tready is high only while the engine is idle.
//  - Each input word yields exactly one output word on m_axis_*: the Q32.32
//    control value in tdata and the saturation flag in tuser.
//  - Gains, windup limit and steps per turn are written through cfg_we /
//    cfg_index / cfg_data while the block is idle.
//  - Clear items go straight to the output stage. Updates run one serial
//    multiplier for the error*dt, P and I products and, when dt is nonzero,
//    for the D product, then a serial divide for the derivative; angular
//    mode with nonzero steps per turn first runs a wrap divide. The run time
//    is set by the bit-serial units, each product's by its multiplier bits.
//  - A finished word sits in an output register; the next input is taken
//    while it waits. If the receiver stalls, the engine holds its next
//    result until the output register frees.
//  - Reset clears the stored error, the integral, the output register and
//    loads the register defaults.
// ----------------------------------------------------------------------------
module pid_controller_windup_angular (
	input  logic         clk,
	input  logic         arst_n,
	// input words
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // error_value, target_angle, actual_angle, time_step
	input  logic [1:0]   s_axis_tuser,  // func
	// output words
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // control
	output logic         m_axis_tuser,  // control_saturated
	// configuration
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [62:0]  cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_ANG, S_PROD, S_CLAMP, S_P, S_I, S_D, S_DIV, S_OUT
	} state_t;

	state_t                             state_q;
	logic                               go_q;
	logic signed [pidw_pkg::ERR_W-1:0]  err_q;
	logic [pidw_pkg::DT_W-1:0]          dt_q;
	logic                               x_neg_q;
	logic signed [pidw_pkg::ERR_W-1:0]  last_err_q;
	logic signed [pidw_pkg::INTEG_W-1:0] integ_q;
	logic signed [pidw_pkg::SUM_W-1:0]  sum_q;
	logic [pidw_pkg::GAIN_W-1:0]        prop_gain_q;
	logic [pidw_pkg::GAIN_W-1:0]        integ_gain_q;
	logic [pidw_pkg::GAIN_W-1:0]        deriv_gain_q;
	logic [pidw_pkg::LIM_W-1:0]         windup_lim_q;
	logic [pidw_pkg::NPT_W-1:0]         npt_q;
	logic                               m_valid_q;
	logic [pidw_pkg::CTRL_W-1:0]        m_data_q;
	logic                               m_user_q;

	pidw_pkg::mul_req_t mul_req;
	pidw_pkg::mul_rsp_t mul_rsp;
	pidw_pkg::div_req_t div_req;
	pidw_pkg::div_rsp_t div_rsp;

	logic                               accept;
	logic signed [pidw_pkg::ANG_W:0]    ang_x;
	logic [pidw_pkg::ANG_W-1:0]         ang_mag;
	logic [pidw_pkg::NPT_W-2:0]         half_turn;
	logic [pidw_pkg::NPT_W-1:0]         rem16;
	logic [pidw_pkg::NPT_W-1:0]         mod16;
	logic [pidw_pkg::NPT_W:0]           wrap17;
	logic [pidw_pkg::ERR_W-1:0]         err_mag;
	logic signed [pidw_pkg::ERR_W:0]    diff;
	logic [pidw_pkg::ERR_W:0]           diff_mag;
	logic [pidw_pkg::GAIN_W-1:0]        pg_mag;
	logic [pidw_pkg::GAIN_W-1:0]        ig_mag;
	logic [pidw_pkg::GAIN_W-1:0]        dg_mag;
	logic [pidw_pkg::INTEG_W-1:0]       integ_mag;
	logic                               d_neg;
	logic                               mul_neg;
	logic signed [pidw_pkg::PROD_W:0]   sprod;
	logic signed [pidw_pkg::INTEG_W-1:0] prod64;
	logic signed [pidw_pkg::INTEG_W:0]  isum;
	logic signed [pidw_pkg::INTEG_W-1:0] isat;
	logic signed [pidw_pkg::INTEG_W-1:0] lim_pos;
	logic signed [pidw_pkg::INTEG_W-1:0] lim_neg;
	logic signed [pidw_pkg::SUM_W-1:0]  dquot;
	logic                               sum_fits;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	// angular wrap operand: target - actual + half turn
	assign half_turn = npt_q[pidw_pkg::NPT_W-1:1];
	assign ang_x   = (pidw_pkg::ANG_W+1)'(signed'(s_axis_tdata[63:32]))
		- (pidw_pkg::ANG_W+1)'(signed'(s_axis_tdata[95:64]))
		+ (pidw_pkg::ANG_W+1)'(half_turn);
	assign ang_mag = ang_x[pidw_pkg::ANG_W] ? pidw_pkg::ANG_W'(-ang_x)
		: pidw_pkg::ANG_W'(ang_x);

	// floor modulo from magnitude remainder, then recentre
	assign rem16  = div_rsp.rem[pidw_pkg::NPT_W-1:0];
	assign mod16  = (x_neg_q && rem16 != '0) ? npt_q - rem16 : rem16;
	assign wrap17 = {1'b0, mod16} - {2'b00, half_turn};

	// operand magnitudes
	assign err_mag   = err_q[pidw_pkg::ERR_W-1] ? pidw_pkg::ERR_W'(-err_q)
		: pidw_pkg::ERR_W'(err_q);
	assign diff      = (pidw_pkg::ERR_W+1)'(err_q) - (pidw_pkg::ERR_W+1)'(last_err_q);
	assign diff_mag  = diff[pidw_pkg::ERR_W] ? (pidw_pkg::ERR_W+1)'(-diff)
		: (pidw_pkg::ERR_W+1)'(diff);
	assign pg_mag    = prop_gain_q[pidw_pkg::GAIN_W-1] ? -prop_gain_q : prop_gain_q;
	assign ig_mag    = integ_gain_q[pidw_pkg::GAIN_W-1] ? -integ_gain_q : integ_gain_q;
	assign dg_mag    = deriv_gain_q[pidw_pkg::GAIN_W-1] ? -deriv_gain_q : deriv_gain_q;
	assign integ_mag = integ_q[pidw_pkg::INTEG_W-1] ? pidw_pkg::INTEG_W'(-integ_q)
		: pidw_pkg::INTEG_W'(integ_q);
	assign d_neg     = deriv_gain_q[pidw_pkg::GAIN_W-1] ^ diff[pidw_pkg::ERR_W];

	// multiplier operand select
	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		mul_neg       = 1'b0;
		case (state_q)
			S_PROD: begin
				mul_req.start = go_q;
				mul_req.a     = pidw_pkg::MUL_A_W'(err_mag);
				mul_req.b     = pidw_pkg::MUL_B_W'(dt_q);
				mul_neg       = err_q[pidw_pkg::ERR_W-1];
			end
			S_P: begin
				mul_req.start = go_q;
				mul_req.a     = pg_mag;
				mul_req.b     = pidw_pkg::MUL_B_W'(err_mag);
				mul_neg       = prop_gain_q[pidw_pkg::GAIN_W-1] ^ err_q[pidw_pkg::ERR_W-1];
			end
			S_I: begin
				mul_req.start = go_q;
				mul_req.a     = ig_mag;
				mul_req.b     = integ_mag;
				mul_neg       = integ_gain_q[pidw_pkg::GAIN_W-1] ^ integ_q[pidw_pkg::INTEG_W-1];
			end
			S_D: begin
				mul_req.start = go_q;
				mul_req.a     = dg_mag;
				mul_req.b     = pidw_pkg::MUL_B_W'(diff_mag);
				mul_neg       = d_neg;
			end
			default: begin
				mul_req.start = 1'b0;
			end
		endcase
	end

	// divider request: angular wrap at accept, derivative after D product
	always_comb begin
		if (state_q == S_IDLE) begin
			div_req.start    = accept && (s_axis_tuser == pidw_pkg::FUNC_ANGULAR)
				&& (npt_q != '0);
			div_req.dividend = {ang_mag, {(pidw_pkg::DIVD_W-pidw_pkg::ANG_W){1'b0}}};
			div_req.divisor  = pidw_pkg::DIVS_W'(npt_q);
			div_req.count    = pidw_pkg::DIV_CNT_ANG;
		end else begin
			div_req.start    = go_q && (state_q == S_DIV);
			div_req.dividend = mul_rsp.prod[pidw_pkg::DIVD_W-1:0];
			div_req.divisor  = dt_q;
			div_req.count    = pidw_pkg::DIV_CNT_DER;
		end
	end

	// signed product, integral add with saturation, clamp limits
	assign sprod   = mul_neg ? -$signed({1'b0, mul_rsp.prod}) : $signed({1'b0, mul_rsp.prod});
	assign prod64  = sprod[pidw_pkg::INTEG_W-1:0];
	assign isum    = (pidw_pkg::INTEG_W+1)'(integ_q) + (pidw_pkg::INTEG_W+1)'(prod64);
	assign isat    = (isum[pidw_pkg::INTEG_W] == isum[pidw_pkg::INTEG_W-1])
		? isum[pidw_pkg::INTEG_W-1:0]
		: {isum[pidw_pkg::INTEG_W], {(pidw_pkg::INTEG_W-1){~isum[pidw_pkg::INTEG_W]}}};
	assign lim_pos = {1'b0, windup_lim_q};
	assign lim_neg = -lim_pos;

	// derivative quotient with sign, truncated toward zero
	assign dquot = d_neg ? -pidw_pkg::SUM_W'(div_rsp.quot) : pidw_pkg::SUM_W'(div_rsp.quot);

	// output range check
	assign sum_fits = (sum_q[pidw_pkg::SUM_W-1:pidw_pkg::CTRL_W-1] == '0)
		|| (sum_q[pidw_pkg::SUM_W-1:pidw_pkg::CTRL_W-1] == '1);

	pidw_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	pidw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			go_q         <= 1'b0;
			err_q        <= '0;
			dt_q         <= '0;
			x_neg_q      <= 1'b0;
			last_err_q   <= '0;
			integ_q      <= '0;
			sum_q        <= '0;
			prop_gain_q  <= pidw_pkg::PROP_GAIN_RST;
			integ_gain_q <= pidw_pkg::INTEG_GAIN_RST;
			deriv_gain_q <= pidw_pkg::DERIV_GAIN_RST;
			windup_lim_q <= pidw_pkg::WINDUP_LIM_RST;
			npt_q        <= pidw_pkg::STEPS_TURN_RST;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
			m_user_q     <= 1'b0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					pidw_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data[pidw_pkg::GAIN_W-1:0];
					pidw_pkg::REG_INTEG_GAIN: integ_gain_q <= cfg_data[pidw_pkg::GAIN_W-1:0];
					pidw_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data[pidw_pkg::GAIN_W-1:0];
					pidw_pkg::REG_WINDUP_LIM: windup_lim_q <= cfg_data[pidw_pkg::LIM_W-1:0];
					pidw_pkg::REG_STEPS_TURN: npt_q        <= cfg_data[pidw_pkg::NPT_W-1:0];
					default: ;
				endcase
			end

			// output word taken; S_OUT refills the register itself
			if (m_valid_q && m_axis_tready && state_q != S_OUT) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						// zero steps per turn gives a zero angular error
						err_q   <= (s_axis_tuser == pidw_pkg::FUNC_ANGULAR && npt_q == '0)
							? '0 : signed'(s_axis_tdata[31:0]);
						dt_q    <= s_axis_tdata[127:96];
						x_neg_q <= ang_x[pidw_pkg::ANG_W];
						sum_q   <= '0;
						go_q    <= 1'b1;
						case (s_axis_tuser)
							pidw_pkg::FUNC_LINEAR: begin
								state_q <= S_PROD;
							end
							pidw_pkg::FUNC_ANGULAR: begin
								if (npt_q == '0) begin
									state_q <= S_PROD;
								end else begin
									state_q <= S_ANG;
								end
							end
							pidw_pkg::FUNC_CLEAR: begin
								last_err_q <= '0;
								integ_q    <= '0;
								state_q    <= S_OUT;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_ANG: begin
					if (div_rsp.done) begin
						err_q   <= signed'({wrap17[pidw_pkg::NPT_W-1:0],
							{(pidw_pkg::ERR_W-pidw_pkg::NPT_W){1'b0}}});
						state_q <= S_PROD;
					end
				end
				S_PROD: begin
					go_q <= 1'b0;
					if (mul_rsp.done) begin
						integ_q <= isat;
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					if (integ_q > lim_pos) begin
						integ_q <= lim_pos;
					end else if (integ_q < lim_neg) begin
						integ_q <= lim_neg;
					end
					go_q    <= 1'b1;
					state_q <= S_P;
				end
				S_P: begin
					go_q <= mul_rsp.done;
					if (mul_rsp.done) begin
						sum_q   <= sum_q + pidw_pkg::SUM_W'(sprod >>> 24);
						state_q <= S_I;
					end
				end
				S_I: begin
					go_q <= mul_rsp.done && (dt_q != '0);
					if (mul_rsp.done) begin
						sum_q <= sum_q + pidw_pkg::SUM_W'(sprod >>> 48);
						if (dt_q == '0) begin
							last_err_q <= err_q;
							state_q    <= S_OUT;
						end else begin
							state_q <= S_D;
						end
					end
				end
				S_D: begin
					go_q <= mul_rsp.done;
					if (mul_rsp.done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					go_q <= 1'b0;
					if (div_rsp.done) begin
						sum_q      <= sum_q + dquot;
						last_err_q <= err_q;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					go_q <= 1'b0;
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						if (sum_fits) begin
							m_data_q <= sum_q[pidw_pkg::CTRL_W-1:0];
							m_user_q <= 1'b0;
						end else begin
							m_data_q <= {sum_q[pidw_pkg::SUM_W-1],
								{(pidw_pkg::CTRL_W-1){~sum_q[pidw_pkg::SUM_W-1]}}};
							m_user_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

@@ src/pidw_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidw_chk
// Port-level checks for the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidw_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [127:0] s_axis_tdata,
	input logic [1:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [63:0]  m_axis_tdata,
	input logic         m_axis_tuser,
	input logic         cfg_we,
	input logic [2:0]   cfg_index,
	input logic [62:0]  cfg_data
);

	// a pending output word is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	// one word in flight: the engine goes busy after taking a word
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

	// a saturated word carries a range limit
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		(m_axis_tdata == 64'h8000_0000_0000_0000) || (m_axis_tdata == 64'h7FFF_FFFF_FFFF_FFFF))
		else $error("saturation flag without limit value");

	// a waiting input word stays put
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
		s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
		else $error("input word changed while waiting");

	// register writes only while idle and drained
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> s_axis_tready && !m_axis_tvalid && !$isunknown({cfg_index, cfg_data}))
		else $error("register write while busy");

endmodule

bind pid_controller_windup_angular pidw_chk u_pidw_chk (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-point PID step with anti-windup clamp.
// Items are fed from a queue through a stream driver with random gaps. A
// local model of the controller predicts each control word, and a monitor
// compares the output words with those predictions in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int CFG_SETTLE = 400;

	typedef struct {
		logic [pidw_pkg::FUNC_W-1:0] func;
		logic [31:0]       err_val;
		logic [31:0]       tgt;
		logic [31:0]       act;
		logic [31:0]       dt;
	} pid_item_t;

	typedef struct {
		logic [63:0] ctrl;
		logic        sat;
	} ctrl_word_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [62:0]  cfg_data = '0;

	pid_controller_windup_angular uut (.*);

	// predictor state and register copies
	logic signed [47:0] kp, ki, kd;
	logic [62:0]        wlim;
	logic [15:0]        npt;
	logic signed [63:0] prev_err;
	logic signed [63:0] integ;

	pid_item_t  pending_items[$];
	ctrl_word_t expected_ctrl[$];
	int         n_errors = 0;
	int         n_words = 0;
	int         n_sat = 0;
	bit         hold_sink = 1'b0;
	bit         long_hold_req = 1'b0;

	initial forever #6 clk = ~clk;

	function automatic logic signed [63:0] wrap_angle(logic signed [31:0] t,
			logic signed [31:0] a);
		logic signed [63:0] n, h, m;
		n = {48'd0, npt};
		if (n == 0)
			return 0;
		h = n / 2;
		m = (64'(t) - 64'(a) + h) % n;
		if (m < 0)
			m += n;
		return (m - h) * 65536;
	endfunction

	// one controller update; advances predictor state
	function automatic ctrl_word_t pid_update(logic signed [63:0] e, logic [31:0] dt);
		logic signed [127:0] prod, acc, lim, p, i, d, sum, mag;
		logic [127:0]        num;
		ctrl_word_t          w;
		prod = 128'(e) * $signed({96'd0, dt});
		acc = 128'(integ) + prod;
		if (acc > 128'sh7FFFFFFFFFFFFFFF)
			acc = 128'sh7FFFFFFFFFFFFFFF;
		else if (acc < -128'sh8000000000000000)
			acc = -128'sh8000000000000000;
		lim = $signed({65'd0, wlim});
		if (acc > lim)
			acc = lim;
		else if (acc < -lim)
			acc = -lim;
		integ = acc[63:0];
		p = (128'(kp) * 128'(e)) >>> 24;
		i = (128'(ki) * acc) >>> 48;
		d = 0;
		if (dt != 0) begin
			mag = (128'(kd) * (128'(e) - 128'(prev_err)));
			num = (mag < 0) ? 128'(-mag) : 128'(mag);
			num = num / {96'd0, dt};
			d = (mag < 0) ? -$signed(num) : $signed(num);
		end
		prev_err = e;
		sum = p + i + d;
		if (sum > 128'sh7FFFFFFFFFFFFFFF) begin
			w.ctrl = 64'h7FFFFFFFFFFFFFFF;
			w.sat = 1'b1;
		end else if (sum < -128'sh8000000000000000) begin
			w.ctrl = 64'h8000000000000000;
			w.sat = 1'b1;
		end else begin
			w.ctrl = sum[63:0];
			w.sat = 1'b0;
		end
		return w;
	endfunction

	function automatic ctrl_word_t predict_ctrl(pid_item_t it);
		ctrl_word_t w;
		w.ctrl = '0;
		w.sat = 1'b0;
		case (it.func)
			pidw_pkg::FUNC_LINEAR: w = pid_update(64'($signed(it.err_val)), it.dt);
			pidw_pkg::FUNC_ANGULAR: w = pid_update(wrap_angle(it.tgt, it.act), it.dt);
			pidw_pkg::FUNC_CLEAR: begin
				prev_err = 0;
				integ = 0;
			end
			default: ;
		endcase
		return w;
	endfunction

	// driver: one word per handshake, random gaps
	int gap_left = 0;
	bit drv_pause = 1'b0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				pid_item_t it;
				it = pending_items.pop_front();
				expected_ctrl.push_back(predict_ctrl(it));
				gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
						: $urandom_range(0, 2);
				if ($urandom_range(0, 3) == 0)
					gap_left = 0;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// keep offering the same word
			end else if (gap_left > 0 || drv_pause || pending_items.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {pending_items[0].dt, pending_items[0].act,
						pending_items[0].tgt, pending_items[0].err_val};
				s_axis_tuser <= pending_items[0].func;
			end
		end
	end

	// receiver stall pattern, with one long hold on request
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold_req && !hold_sink) begin
				hold_sink <= 1'b1;
				stall_left = 3000;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
				if (stall_left == 0)
					hold_sink <= 1'b0;
			end else if ($urandom_range(0, 4) == 0) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
						: $urandom_range(1, 4);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// monitor: compare each output word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_ctrl.size() == 0) begin
				$error("unexpected word control=%h", m_axis_tdata);
				n_errors++;
			end else begin
				ctrl_word_t w;
				w = expected_ctrl.pop_front();
				if (m_axis_tdata !== w.ctrl) begin
					$error("control expected %h actual %h", w.ctrl, m_axis_tdata);
					n_errors++;
				end
				if (m_axis_tuser !== w.sat) begin
					$error("control_saturated expected %0b actual %0b", w.sat,
							m_axis_tuser);
					n_errors++;
				end
				n_words++;
				if (w.sat)
					n_sat++;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [62:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pidw_pkg::REG_PROP_GAIN: kp = val[47:0];
			pidw_pkg::REG_INTEG_GAIN: ki = val[47:0];
			pidw_pkg::REG_DERIV_GAIN: kd = val[47:0];
			pidw_pkg::REG_WINDUP_LIM: wlim = val;
			pidw_pkg::REG_STEPS_TURN: npt = val[15:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || s_axis_tvalid || expected_ctrl.size() != 0)
			@(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
	endtask

	task automatic add_item(logic [1:0] f, logic [31:0] e, logic [31:0] t,
			logic [31:0] a, logic [31:0] dt);
		pid_item_t it;
		it.func = f;
		it.err_val = e;
		it.tgt = t;
		it.act = a;
		it.dt = dt;
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return $urandom_range(0, 20) - 10;
			3: return {{16{1'b0}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_dt();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFFFFFF;
			2: return $urandom_range(1, 255);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [47:0] rand_gain();
		case ($urandom_range(0, 4))
			0: return 48'h7FFFFFFFFFFF;
			1: return 48'h800000000000;
			2: return {{24{1'b0}}, 24'($urandom)};
			default: return {16'($urandom), $urandom};
		endcase
	endfunction

	task automatic random_batch(int n);
		logic [1:0] f;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 19))
				0: f = pidw_pkg::FUNC_CLEAR;
				1: f = pidw_pkg::FUNC_UNUSED;
				2, 3, 4, 5, 6, 7, 8: f = pidw_pkg::FUNC_ANGULAR;
				default: f = pidw_pkg::FUNC_LINEAR;
			endcase
			add_item(f, rand_word(), rand_word(), rand_word(), rand_dt());
		end
	endtask

	initial begin
		kp = pidw_pkg::PROP_GAIN_RST;
		ki = pidw_pkg::INTEG_GAIN_RST;
		kd = pidw_pkg::DERIV_GAIN_RST;
		wlim = pidw_pkg::WINDUP_LIM_RST;
		npt = pidw_pkg::STEPS_TURN_RST;
		prev_err = 0;
		integ = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: defaults, field extremes, every kind
		add_item(pidw_pkg::FUNC_LINEAR, 32'h00010000, 0, 0, 32'h01000000);
		add_item(pidw_pkg::FUNC_LINEAR, 32'h7FFFFFFF, 0, 0, 32'hFFFFFFFF);
		add_item(pidw_pkg::FUNC_LINEAR, 32'h80000000, 0, 0, 32'h00000001);
		add_item(pidw_pkg::FUNC_LINEAR, 32'h12345678, 0, 0, 0);
		add_item(pidw_pkg::FUNC_ANGULAR, 0, 32'h7FFFFFFF, 32'h80000000, 32'h00100000);
		add_item(pidw_pkg::FUNC_ANGULAR, 0, 32'h80000000, 32'h7FFFFFFF, 32'h00100000);
		add_item(pidw_pkg::FUNC_ANGULAR, 0, 2048, 0, 32'h00010000);
		add_item(pidw_pkg::FUNC_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
				32'hFFFFFFFF);
		add_item(pidw_pkg::FUNC_UNUSED, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
				32'hAAAAAAAA);
		add_item(pidw_pkg::FUNC_LINEAR, 32'hFFFF0000, 0, 0, 32'h00000010);
		wait_drained();

		// extreme gains with a small windup limit; integral clamps
		write_reg(pidw_pkg::REG_PROP_GAIN, 63'h7FFFFFFFFFFF);
		write_reg(pidw_pkg::REG_INTEG_GAIN, 63'h7FFFFFFFFFFF);
		write_reg(pidw_pkg::REG_DERIV_GAIN, 63'h800000000000);
		write_reg(pidw_pkg::REG_WINDUP_LIM, 63'd1 << 40);
		write_reg(pidw_pkg::REG_STEPS_TURN, 63'd0);
		add_item(pidw_pkg::FUNC_LINEAR, 32'h7FFFFFFF, 0, 0, 32'hFFFFFFFF);
		add_item(pidw_pkg::FUNC_LINEAR, 32'h80000000, 0, 0, 32'hFFFFFFFF);
		add_item(pidw_pkg::FUNC_ANGULAR, 0, 32'h7FFFFFFF, 32'h80000000, 32'h00000001);
		add_item(pidw_pkg::FUNC_LINEAR, 32'h7FFFFFFF, 0, 0, 32'h00000001);
		wait_drained();
		write_reg(pidw_pkg::REG_WINDUP_LIM, 63'd0);
		write_reg(pidw_pkg::REG_STEPS_TURN, 63'd1);
		add_item(pidw_pkg::FUNC_LINEAR, 32'h40000000, 0, 0, 32'h01000000);
		add_item(pidw_pkg::FUNC_ANGULAR, 0, 5, 3, 32'h01000000);
		wait_drained();

		// random phases over several register settings
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(pidw_pkg::REG_PROP_GAIN, 63'(rand_gain()));
			write_reg(pidw_pkg::REG_INTEG_GAIN, 63'(rand_gain()));
			write_reg(pidw_pkg::REG_DERIV_GAIN, 63'(rand_gain()));
			case (ph % 4)
				0: write_reg(pidw_pkg::REG_WINDUP_LIM, {63{1'b1}});
				1: write_reg(pidw_pkg::REG_WINDUP_LIM, 63'($urandom) << 24);
				2: write_reg(pidw_pkg::REG_WINDUP_LIM, 63'({$urandom, $urandom}));
				default: write_reg(pidw_pkg::REG_WINDUP_LIM, 63'd0);
			endcase
			case (ph % 3)
				0: write_reg(pidw_pkg::REG_STEPS_TURN, 63'd65535);
				1: write_reg(pidw_pkg::REG_STEPS_TURN, 63'($urandom_range(1, 65535)));
				default: write_reg(pidw_pkg::REG_STEPS_TURN, 63'($urandom_range(1, 8)));
			endcase
			if (ph == 3) begin
				// long receiver hold while the sender keeps offering
				long_hold_req = 1'b1;
				random_batch(40);
				wait (hold_sink);
				long_hold_req = 1'b0;
				wait (!hold_sink);
			end
			if (ph == 6) begin
				// sender pauses until every result is back
				random_batch(20);
				while (pending_items.size() != 0) @(posedge clk);
				drv_pause = 1'b1;
				while (expected_ctrl.size() != 0) @(posedge clk);
				drv_pause = 1'b0;
			end
			random_batch(140);
			wait_drained();
		end

		$display("tb: %0d control words checked, %0d saturated, 12 register settings",
				n_words, n_sat);
		$display("tb: linear, angular, clear and unused kinds with long stalls covered");
		if (n_errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// watchdog
	initial begin
		#(64'd100_000_000);
		$display("tb: errors");
		$finish;
	end

endmodule
